// ===== sv/csr_pkg.sv =====
package csr_pkg;

  localparam int CANVAS_W = 64;
  localparam int CANVAS_H = 64;
  localparam int ROW_W    = 64;
  localparam int ROW_AW   = $clog2(CANVAS_H);
  localparam int COL_AW   = $clog2(CANVAS_W);

  localparam logic [2:0] OP_CLEAR  = 3'd0;
  localparam logic [2:0] OP_LINE   = 3'd1;
  localparam logic [2:0] OP_RECT   = 3'd2;
  localparam logic [2:0] OP_CIRCLE = 3'd3;
  localparam logic [2:0] OP_READ   = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_LINE_START,
    ST_PIX_RD,
    ST_PIX_WR,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic       load;
    logic       clear;
    logic       line_init;
    logic [1:0] seg;
    logic       circ_init;
    logic       pix_rd;
    logic       pix_wr;
    logic       step;
    logic       row_rd;
    logic       res_load;
  } dp_cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic       r_neg;
    logic       last;
    logic       out_full;
  } dp_status_t;

endpackage

// ===== sv/csr_ctrl.sv =====
module csr_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                out_ready,
  input  csr_pkg::dp_status_t status,
  output csr_pkg::dp_cmd_t    cmd
);

  csr_pkg::state_t state, state_next;
  logic [1:0] seg, seg_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= csr_pkg::ST_IDLE;
      seg   <= 2'd0;
    end else begin
      state <= state_next;
      seg   <= seg_next;
    end
  end

  always_comb begin
    state_next = state;
    seg_next   = seg;
    cmd        = '0;
    cmd.seg    = seg;
    in_ready   = 1'b0;
    unique case (state)
      csr_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = csr_pkg::ST_DISPATCH;
        end
      end
      csr_pkg::ST_DISPATCH: begin
        seg_next = 2'd0;
        unique case (status.op)
          csr_pkg::OP_CLEAR: begin
            cmd.clear  = 1'b1;
            state_next = csr_pkg::ST_FINISH;
          end
          csr_pkg::OP_LINE, csr_pkg::OP_RECT: begin
            state_next = csr_pkg::ST_LINE_START;
          end
          csr_pkg::OP_CIRCLE: begin
            if (status.r_neg) begin
              state_next = csr_pkg::ST_FINISH;
            end else begin
              cmd.circ_init = 1'b1;
              state_next    = csr_pkg::ST_PIX_RD;
            end
          end
          csr_pkg::OP_READ: begin
            cmd.row_rd = 1'b1;
            state_next = csr_pkg::ST_FINISH;
          end
          default: begin
            state_next = csr_pkg::ST_FINISH;
          end
        endcase
      end
      csr_pkg::ST_LINE_START: begin
        cmd.line_init = 1'b1;
        state_next    = csr_pkg::ST_PIX_RD;
      end
      csr_pkg::ST_PIX_RD: begin
        cmd.pix_rd = 1'b1;
        state_next = csr_pkg::ST_PIX_WR;
      end
      csr_pkg::ST_PIX_WR: begin
        cmd.pix_wr = 1'b1;
        if (!status.last) begin
          cmd.step   = 1'b1;
          state_next = csr_pkg::ST_PIX_RD;
        end else if (status.op == csr_pkg::OP_RECT && seg != 2'd3) begin
          seg_next   = seg + 2'd1;
          state_next = csr_pkg::ST_LINE_START;
        end else begin
          state_next = csr_pkg::ST_FINISH;
        end
      end
      csr_pkg::ST_FINISH: begin
        if (!status.out_full || out_ready) begin
          cmd.res_load = 1'b1;
          state_next   = csr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = csr_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== sv/csr_dp.sv =====
module csr_dp (
  input  logic                         clk,
  input  logic                         rst,
  input  csr_pkg::dp_cmd_t             cmd,
  output csr_pkg::dp_status_t          status,
  input  logic [2:0]                   opcode,
  input  logic signed [8:0]            pos_x,
  input  logic signed [8:0]            pos_y,
  input  logic signed [8:0]            arg_a,
  input  logic signed [8:0]            arg_b,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [csr_pkg::ROW_W-1:0]    row_bits,
  output logic                         row_valid
);

  logic [2:0]        op_r;
  logic signed [8:0] px_r, py_r, a_r, b_r;

  logic              circ_mode;
  logic signed [9:0] lx0, ly0;
  logic [9:0]        adx, ady, n, cnt, qx, qy, ax, ay;
  logic              sx, sy;
  logic signed [9:0] di, dj;
  logic [17:0]       lo, hi;

  logic [csr_pkg::ROW_W-1:0] mem [csr_pkg::CANVAS_H];
  logic [csr_pkg::CANVAS_H-1:0] row_ok;
  logic [csr_pkg::ROW_W-1:0] rdata;
  logic                      rvalid;

  logic signed [10:0] pix_x, pix_y;
  logic               pix_hit;

  logic signed [9:0]  xw, yh, e0x, e0y, e1x, e1y;
  logic signed [10:0] dx, dy;
  logic [9:0]         adx_c, ady_c, n_c;
  logic signed [10:0] lx_pt, ly_pt, cx_pt, cy_pt, cur_x, cur_y;
  logic signed [19:0] di_sq, dj_sq;
  logic [17:0]        d;
  logic               hit, pix_on, mem_we, rd_ok;
  logic [8:0]         r_u;
  logic [9:0]         rp1;
  logic signed [9:0]  r_s;
  logic [10:0]        axs, ays;
  logic [csr_pkg::ROW_AW-1:0] rd_addr, wr_addr;
  logic [csr_pkg::ROW_W-1:0]  wdata, rbase;

  assign xw = 10'(px_r) + 10'(a_r);
  assign yh = 10'(py_r) + 10'(b_r);

  always_comb begin
    e0x = 10'(px_r);
    e0y = 10'(py_r);
    e1x = 10'(a_r);
    e1y = 10'(b_r);
    if (op_r == csr_pkg::OP_RECT) begin
      unique case (cmd.seg)
        2'd0: begin e0x = 10'(px_r); e0y = 10'(py_r); e1x = xw; e1y = 10'(py_r); end
        2'd1: begin e0x = 10'(px_r); e0y = 10'(py_r); e1x = 10'(px_r); e1y = yh; end
        2'd2: begin e0x = xw; e0y = 10'(py_r); e1x = xw; e1y = yh; end
        default: begin e0x = 10'(px_r); e0y = yh; e1x = xw; e1y = yh; end
      endcase
    end
  end

  assign dx    = 11'(e1x) - 11'(e0x);
  assign dy    = 11'(e1y) - 11'(e0y);
  assign adx_c = dx[10] ? 10'(-dx) : 10'(dx);
  assign ady_c = dy[10] ? 10'(-dy) : 10'(dy);
  assign n_c   = (adx_c > ady_c) ? adx_c : ady_c;

  assign lx_pt = 11'(lx0) + (sx ? -$signed({1'b0, qx}) : $signed({1'b0, qx}));
  assign ly_pt = 11'(ly0) + (sy ? -$signed({1'b0, qy}) : $signed({1'b0, qy}));
  assign cx_pt = 11'(px_r) + 11'(di);
  assign cy_pt = 11'(py_r) + 11'(dj);
  assign cur_x = circ_mode ? cx_pt : lx_pt;
  assign cur_y = circ_mode ? cy_pt : ly_pt;

  assign di_sq = di * di;
  assign dj_sq = dj * dj;
  assign d     = di_sq[17:0] + dj_sq[17:0];
  assign hit   = !circ_mode || (d >= lo && d < hi);

  assign r_u = a_r;
  assign rp1 = 10'(r_u) + 10'd1;
  assign r_s = 10'(a_r);

  assign status.op       = op_r;
  assign status.r_neg    = a_r[8];
  assign status.last     = circ_mode ? (di == r_s && dj == r_s) : (cnt == n);
  assign status.out_full = out_valid;

  assign pix_on = !pix_x[10] && pix_x[9:0] < 10'(csr_pkg::CANVAS_W)
               && !pix_y[10] && pix_y[9:0] < 10'(csr_pkg::CANVAS_H);
  assign mem_we  = cmd.pix_wr && pix_hit && pix_on;
  assign wr_addr = pix_y[csr_pkg::ROW_AW-1:0];
  assign rd_addr = cmd.row_rd ? py_r[csr_pkg::ROW_AW-1:0] : cur_y[csr_pkg::ROW_AW-1:0];
  assign rbase   = rvalid ? rdata : '0;
  assign wdata   = rbase | (csr_pkg::ROW_W'(1) << pix_x[csr_pkg::COL_AW-1:0]);
  assign rd_ok   = op_r == csr_pkg::OP_READ && !py_r[8]
                && {1'b0, py_r} < 10'(csr_pkg::CANVAS_H);

  assign axs = 11'(ax) + 11'(adx);
  assign ays = 11'(ay) + 11'(ady);

  // canvas rows
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wdata;
    end
    if (cmd.pix_rd || cmd.row_rd) begin
      rdata <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      row_ok <= '0;
    end else if (mem_we) begin
      row_ok[wr_addr] <= 1'b1;
    end
    if (cmd.pix_rd || cmd.row_rd) begin
      rvalid <= row_ok[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r <= opcode;
      px_r <= pos_x;
      py_r <= pos_y;
      a_r  <= arg_a;
      b_r  <= arg_b;
    end
    if (cmd.line_init) begin
      circ_mode <= 1'b0;
      lx0 <= e0x;
      ly0 <= e0y;
      adx <= adx_c;
      ady <= ady_c;
      sx  <= dx[10];
      sy  <= dy[10];
      n   <= n_c;
      cnt <= '0;
      qx  <= '0;
      qy  <= '0;
      ax  <= '0;
      ay  <= '0;
    end
    if (cmd.circ_init) begin
      circ_mode <= 1'b1;
      di <= -r_s;
      dj <= -r_s;
      lo <= 18'(r_u) * 18'(r_u);
      hi <= 18'(rp1) * 18'(rp1);
    end
    if (cmd.pix_rd) begin
      pix_x   <= cur_x;
      pix_y   <= cur_y;
      pix_hit <= hit;
    end
    if (cmd.step) begin
      if (circ_mode) begin
        if (dj == r_s) begin
          dj <= -r_s;
          di <= di + 10'sd1;
        end else begin
          dj <= dj + 10'sd1;
        end
      end else begin
        cnt <= cnt + 10'd1;
        if (axs >= 11'(n)) begin
          ax <= 10'(axs - 11'(n));
          qx <= qx + 10'd1;
        end else begin
          ax <= axs[9:0];
        end
        if (ays >= 11'(n)) begin
          ay <= 10'(ays - 11'(n));
          qy <= qy + 10'd1;
        end else begin
          ay <= ays[9:0];
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.res_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (cmd.res_load) begin
      row_valid <= rd_ok;
      row_bits  <= rd_ok ? rbase : '0;
    end
  end

endmodule

// ===== sv/canvas_shape_rasterizer.sv =====
// One-bit 64 by 64 canvas taking one command at a time: clear, line, rectangle outline,
// circle ring or row read, each giving exactly one result. Every plotted pixel is a
// read-modify-write of its canvas row in the row memory, a read state and then a write
// state per pixel. A rectangle is drawn as four line sides in turn; clear, row read,
// negative radius and unknown commands plot nothing. The result waits to be loaded while
// the output still holds an unaccepted result. Clear is immediate through per-row valid
// bits; no clearing pass after reset.
// A new request is taken while the previous result still waits at the output.
module canvas_shape_rasterizer (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [2:0]                opcode,
  input  logic signed [8:0]         pos_x,
  input  logic signed [8:0]         pos_y,
  input  logic signed [8:0]         arg_a,
  input  logic signed [8:0]         arg_b,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [csr_pkg::ROW_W-1:0] row_bits,
  output logic                      row_valid
);

  csr_pkg::dp_cmd_t    cmd;
  csr_pkg::dp_status_t status;

  csr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_ready(out_ready),
    .status   (status),
    .cmd      (cmd)
  );

  csr_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .status   (status),
    .opcode   (opcode),
    .pos_x    (pos_x),
    .pos_y    (pos_y),
    .arg_a    (arg_a),
    .arg_b    (arg_b),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .row_bits (row_bits),
    .row_valid(row_valid)
  );

`ifndef SYNTHESIS
  a_busy_after_request: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request accepted while busy");

  a_write_after_read: assert property (@(posedge clk) disable iff (rst)
    cmd.pix_wr |-> $past(cmd.pix_rd))
    else $error("pixel write without row read");

  a_invalid_row_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !row_valid) |-> (row_bits == '0))
    else $error("row bits set without valid row");
`endif

endmodule
